// ----- design/tcbw_pkg.sv -----
package tcbw_pkg;

    localparam logic [1:0] MODE_PRINT  = 2'd0;
    localparam logic [1:0] MODE_LOCATE = 2'd1;
    localparam logic [1:0] MODE_FILL   = 2'd2;
    localparam logic [1:0] MODE_READ   = 2'd3;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_TAB    = 3'd2;
    localparam logic [2:0] REG_FG     = 3'd3;
    localparam logic [2:0] REG_BG     = 3'd4;
    localparam logic [2:0] REG_ATTR   = 3'd5;

    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_DEL = 8'h7F;

    localparam logic [7:0] TAB_FALLBACK = 8'd8;
    localparam logic signed [12:0] CUR_MAX = 13'sd2047;
    localparam logic signed [12:0] CUR_MIN = -13'sd2048;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;      // clear the cell at the clear counter
        logic latch;      // capture the accepted transaction
        logic div_step;   // one bit of the tab remainder
        logic exec;       // apply the print or locate action
        logic fill_init;  // compute the clipped rectangle
        logic fill_wr;    // write the current fill cell and advance
        logic rd_req;     // issue the read
        logic done;       // present the result
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic div_busy;
        logic fill_empty;
        logic fill_last;
    } t_status;

    function automatic logic signed [11:0] sat12(input logic signed [12:0] v);
        logic signed [11:0] r;
        if (v > CUR_MAX) r = 12'sd2047;
        else if (v < CUR_MIN) r = -12'sd2048;
        else r = v[11:0];
        return r;
    endfunction

endpackage

// ----- design/tcbw_ctrl.sv -----
module tcbw_ctrl
    import tcbw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [1:0] i_mode,
    input  t_status    i_status,
    output logic       busy,
    output t_cmd       o_cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_FINIT = 3'd3;
    localparam logic [2:0] ST_FILL  = 3'd4;
    localparam logic [2:0] ST_READ  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state = (i_mode == MODE_FILL) ? ST_FINIT
                            : (i_mode == MODE_READ) ? ST_READ : ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_status.div_busy) begin
                    o_cmd.div_step = 1'b1;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state = ST_DONE;
                end
            end
            ST_FINIT: begin
                o_cmd.fill_init = 1'b1;
                n_state = ST_FILL;
            end
            ST_FILL: begin
                if (i_status.fill_empty) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.fill_wr = 1'b1;
                    if (i_status.fill_last) n_state = ST_DONE;
                end
            end
            ST_READ: begin
                o_cmd.rd_req = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                o_cmd.done = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ----- design/tcbw_datapath.sv -----
module tcbw_datapath
    import tcbw_pkg::*;
#(
    parameter int MAX_COLS    = 128,
    parameter int MAX_ROWS    = 64,
    parameter int GLYPH_BYTES = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic [7:0]         i_grid_width,
    input  logic [6:0]         i_grid_height,
    input  logic [7:0]         i_tab_stop,
    input  logic [7:0]         i_draw_fg,
    input  logic [7:0]         i_draw_bg,
    input  logic [15:0]        i_draw_attr,
    input  logic [1:0]         i_mode,
    input  logic [31:0]        i_char_code,
    input  logic [2:0]         i_char_len,
    input  logic signed [11:0] i_pos_x,
    input  logic signed [11:0] i_pos_y,
    input  logic signed [11:0] i_rect_w,
    input  logic signed [11:0] i_rect_h,
    input  logic [7:0]         i_fill_fg,
    input  logic [7:0]         i_fill_bg,
    input  logic [15:0]        i_fill_attr,
    input  logic [3:0]         i_fill_mask,
    output logic               o_valid,
    output logic signed [11:0] o_cursor_x,
    output logic signed [11:0] o_cursor_y,
    output logic [31:0]        o_cell_char,
    output logic [2:0]         o_cell_len,
    output logic [7:0]         o_cell_fg,
    output logic [7:0]         o_cell_bg,
    output logic [15:0]        o_cell_attr,
    output logic               o_cell_damaged,
    output logic               o_any_damage
);

    localparam int CELLS = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);

    logic [34:0] r_glyph_mem [CELLS];
    logic [31:0] r_style_mem [CELLS];
    logic        r_dmg_mem   [CELLS];

    logic [AW-1:0] r_clr;
    logic signed [11:0] r_cx, r_cy;
    logic r_seen;

    logic [1:0]  r_mode;
    logic [31:0] r_code;
    logic [2:0]  r_len;
    logic signed [11:0] r_px, r_py, r_rw, r_rh;
    logic [7:0]  r_ffg, r_fbg;
    logic [15:0] r_fat;
    logic [3:0]  r_fmask;

    logic [CW-1:0] r_fx0, r_fx1, r_fx;
    logic [RW-1:0] r_fy1, r_fy;
    logic          r_fempty;
    logic          r_rd_ok;

    logic [34:0] r_rd_glyph;
    logic [31:0] r_rd_style;
    logic        r_rd_dmg;

    // The tab remainder is formed from the cursor magnitude, one bit per cycle.
    logic [11:0] r_div_a;
    logic [7:0]  r_div_rem;
    logic [3:0]  r_div_cnt;
    logic [11:0] cx_mag;
    logic [8:0]  div_trial;

    // Effective grid size.
    logic [CW-1:0] eff_w;
    logic [RW-1:0] eff_h;
    always_comb begin
        if (i_grid_width == 8'd0) eff_w = CW'(1);
        else if (32'(i_grid_width) > MAX_COLS) eff_w = CW'(MAX_COLS);
        else eff_w = CW'(i_grid_width);
        if (i_grid_height == 7'd0) eff_h = RW'(1);
        else if (32'(i_grid_height) > MAX_ROWS) eff_h = RW'(MAX_ROWS);
        else eff_h = RW'(i_grid_height);
    end

    logic [2:0] nlen;
    logic [31:0] gmask;
    logic [34:0] glyph;
    always_comb begin
        nlen = (r_len == 3'd0) ? 3'd1 : r_len;
        if (nlen > 3'(GLYPH_BYTES)) nlen = 3'(GLYPH_BYTES);
        case (nlen)
            3'd1:    gmask = 32'h0000_00FF;
            3'd2:    gmask = 32'h0000_FFFF;
            3'd3:    gmask = 32'h00FF_FFFF;
            default: gmask = 32'hFFFF_FFFF;
        endcase
        glyph = {nlen, r_code & gmask};
    end

    // Cell address: row * width + col.
    function automatic logic [AW-1:0] addr(input logic [RW-1:0] row,
                                           input logic [CW-1:0] col,
                                           input logic [CW-1:0] w);
        logic [AW+CW-1:0] p;
        p = (AW+CW)'(row) * (AW+CW)'(w) + (AW+CW)'(col);
        return p[AW-1:0];
    endfunction

    // Print decoding.
    logic [7:0] b;
    logic on_grid, is_ctrl, do_print_wr;
    logic signed [12:0] cx13, cy13;
    logic [7:0] ts;
    logic [7:0] tab_rem;
    logic signed [11:0] n_cx, n_cy;
    logic signed [12:0] adv;
    always_comb begin
        b    = r_code[7:0];
        cx13 = 13'(r_cx);
        cy13 = 13'(r_cy);
        ts   = (i_tab_stop == 8'd0) ? TAB_FALLBACK : i_tab_stop;
        tab_rem = r_div_rem;
        on_grid = !r_cx[11] && !r_cy[11] && (r_cx < 12'(eff_w)) && (r_cy < 12'(eff_h));
        is_ctrl = (nlen == 3'd1) && (b < 8'd32 || b == CH_DEL);
        do_print_wr = 1'b0;
        n_cx = r_cx;
        n_cy = r_cy;
        adv  = cx13 + 13'sd1;
        case (b)
            CH_LF: begin
                n_cy = sat12(cy13 + 13'sd1);
                n_cx = '0;
            end
            CH_CR: n_cx = '0;
            CH_FF, CH_VT: n_cy = sat12(cy13 + 13'sd1);
            CH_BS: if (r_cx > 12'sd0) n_cx = r_cx - 12'sd1;
            CH_TAB: begin
                if (!r_cx[11]) begin
                    n_cx = sat12(cx13 + $signed(13'(ts)) - $signed(13'(tab_rem)));
                end else if (tab_rem == 8'd0) begin
                    n_cx = sat12(cx13 + $signed(13'(ts)));
                end else begin
                    n_cx = sat12(cx13 + $signed(13'(tab_rem)));
                end
            end
            default: begin
                do_print_wr = on_grid && !is_ctrl;
                if (adv >= $signed(13'(eff_w))) begin
                    n_cx = '0;
                    n_cy = sat12(cy13 + 13'sd1);
                end else begin
                    n_cx = adv[11:0];
                end
            end
        endcase
    end

    assign cx_mag    = r_cx[11] ? (~r_cx + 12'sd1) : r_cx;
    assign div_trial = {r_div_rem, r_div_a[11]};

    // Fill clipping.
    logic signed [13:0] cdx, cdy, crw, crh;
    logic f_empty;
    always_comb begin
        cdx = 14'(r_px);
        cdy = 14'(r_py);
        crw = 14'(r_rw);
        crh = 14'(r_rh);
        if (cdx < 0) begin crw = crw + cdx; cdx = '0; end
        if (cdy < 0) begin crh = crh + cdy; cdy = '0; end
        if (cdx + crw > $signed(14'(eff_w))) crw = 14'(eff_w) - cdx;
        if (cdy + crh > $signed(14'(eff_h))) crh = 14'(eff_h) - cdy;
        f_empty = (crw <= 0) || (crh <= 0);
    end

    logic [3:0] fm;
    assign fm = (r_fmask == 4'd0) ? 4'hF : r_fmask;
    logic f_last_x, f_last_y;
    assign f_last_x = (r_fx + CW'(1) == r_fx1);
    assign f_last_y = (r_fy + RW'(1) == r_fy1);

    assign o_status.clear_last = (r_clr == AW'(CELLS - 1));
    assign o_status.div_busy   = (r_div_cnt != 4'd0);
    assign o_status.fill_empty = r_fempty;
    assign o_status.fill_last  = f_last_x && f_last_y;

    // Read address check.
    logic rd_ok;
    assign rd_ok = !r_px[11] && !r_py[11] && (r_px < 12'(eff_w)) && (r_py < 12'(eff_h));

    logic [AW-1:0] pa, fa, ra;
    assign pa = addr(r_cy[RW-1:0], r_cx[CW-1:0], eff_w);
    assign fa = addr(r_fy, r_fx, eff_w);
    assign ra = addr(r_py[RW-1:0], r_px[CW-1:0], eff_w);

    logic          we;
    logic [AW-1:0] wa;
    logic          wg;
    logic [3:0]    ws;
    logic [34:0]   wgd;
    logic [31:0]   wsd;
    always_comb begin
        we = 1'b0; wa = pa; wg = 1'b0; ws = 4'h0; wgd = glyph;
        wsd = {i_draw_attr, i_draw_bg, i_draw_fg};
        if (i_cmd.clear) begin
            we = 1'b1; wa = r_clr; wg = 1'b1; ws = 4'hF; wgd = '0; wsd = '0;
        end else if (i_cmd.exec && r_mode == MODE_PRINT && do_print_wr) begin
            we = 1'b1; wa = pa; wg = 1'b1; ws = 4'hF;
        end else if (i_cmd.fill_wr) begin
            we = 1'b1; wa = fa; wg = fm[0]; ws = {fm[3], fm[3], fm[2], fm[1]};
            wsd = {r_fat, r_fbg, r_ffg};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            if (wg) r_glyph_mem[wa] <= wgd;
            if (ws[0]) r_style_mem[wa][7:0]   <= wsd[7:0];
            if (ws[1]) r_style_mem[wa][15:8]  <= wsd[15:8];
            if (ws[2]) r_style_mem[wa][23:16] <= wsd[23:16];
            if (ws[3]) r_style_mem[wa][31:24] <= wsd[31:24];
            r_dmg_mem[wa] <= !i_cmd.clear;
        end
        if (i_cmd.rd_req) begin
            r_rd_glyph <= r_glyph_mem[ra];
            r_rd_style <= r_style_mem[ra];
            r_rd_dmg   <= r_dmg_mem[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode <= i_mode; r_code <= i_char_code; r_len <= i_char_len;
            r_px <= i_pos_x; r_py <= i_pos_y; r_rw <= i_rect_w; r_rh <= i_rect_h;
            r_ffg <= i_fill_fg; r_fbg <= i_fill_bg; r_fat <= i_fill_attr;
            r_fmask <= i_fill_mask;
        end
        if (i_cmd.rd_req) r_rd_ok <= rd_ok;
        if (i_cmd.fill_init) begin
            r_fx0 <= cdx[CW-1:0];
            r_fx  <= cdx[CW-1:0];
            r_fx1 <= CW'(cdx + crw);
            r_fy  <= cdy[RW-1:0];
            r_fy1 <= RW'(cdy + crh);
        end else if (i_cmd.fill_wr) begin
            if (f_last_x) begin
                r_fx <= r_fx0;
                r_fy <= r_fy + RW'(1);
            end else begin
                r_fx <= r_fx + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_cx      <= '0;
            r_cy      <= '0;
            r_seen    <= 1'b0;
            r_fempty  <= 1'b1;
            o_valid   <= 1'b0;
            r_div_a   <= '0;
            r_div_rem <= '0;
            r_div_cnt <= '0;
        end else begin
            o_valid <= i_cmd.done;
            if (i_cmd.clear) r_clr <= r_clr + AW'(1);
            if (i_cmd.fill_init) r_fempty <= f_empty;
            if (we && !i_cmd.clear) r_seen <= 1'b1;
            if (i_cmd.latch) begin
                r_div_a   <= cx_mag;
                r_div_rem <= '0;
                r_div_cnt <= (i_mode == MODE_PRINT && i_char_code[7:0] == CH_TAB) ?
                             4'd12 : 4'd0;
            end else if (i_cmd.div_step) begin
                r_div_a   <= {r_div_a[10:0], 1'b0};
                r_div_rem <= (div_trial >= {1'b0, ts}) ? 8'(div_trial - {1'b0, ts})
                                                       : div_trial[7:0];
                r_div_cnt <= r_div_cnt - 4'd1;
            end
            if (i_cmd.exec) begin
                if (r_mode == MODE_LOCATE) begin
                    r_cx <= r_px;
                    r_cy <= r_py;
                end else begin
                    r_cx <= n_cx;
                    r_cy <= n_cy;
                end
            end
        end
    end

    logic show;
    assign show = (r_mode == MODE_READ) && r_rd_ok;
    assign o_cursor_x     = r_cx;
    assign o_cursor_y     = r_cy;
    assign o_cell_char    = show ? r_rd_glyph[31:0]  : '0;
    assign o_cell_len     = show ? r_rd_glyph[34:32] : '0;
    assign o_cell_fg      = show ? r_rd_style[7:0]   : '0;
    assign o_cell_bg      = show ? r_rd_style[15:8]  : '0;
    assign o_cell_attr    = show ? r_rd_style[31:16] : '0;
    assign o_cell_damaged = show ? r_rd_dmg : 1'b0;
    assign o_any_damage   = r_seen;

endmodule

// ----- design/text_cell_buffer_writer_unit.sv -----
// Character-cell screen store with a cursor. Pulse start while busy is low;
// the result appears on the o_ ports for one cycle marked by o_valid, and the
// receiver cannot stall it. After start, print and locate pass through an
// execute state, a fill through a clip state and a write state, and a read
// through a read state; each then ends in a done state that registers
// o_valid. A TAB print first forms the tab remainder one bit per cycle. Fill
// cells are written one per cycle through the single store write port. After
// reset the store is cleared one cell per cycle, with busy high.
module text_cell_buffer_writer_unit
    import tcbw_pkg::*;
#(
    parameter int MAX_COLS    = 128,
    parameter int MAX_ROWS    = 64,
    parameter int GLYPH_BYTES = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_mode,
    input  logic [31:0]        i_char_code,
    input  logic [2:0]         i_char_len,
    input  logic signed [11:0] i_pos_x,
    input  logic signed [11:0] i_pos_y,
    input  logic signed [11:0] i_rect_w,
    input  logic signed [11:0] i_rect_h,
    input  logic [7:0]         i_fill_fg,
    input  logic [7:0]         i_fill_bg,
    input  logic [15:0]        i_fill_attr,
    input  logic [3:0]         i_fill_mask,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic               o_valid,
    output logic signed [11:0] o_cursor_x,
    output logic signed [11:0] o_cursor_y,
    output logic [31:0]        o_cell_char,
    output logic [2:0]         o_cell_len,
    output logic [7:0]         o_cell_fg,
    output logic [7:0]         o_cell_bg,
    output logic [15:0]        o_cell_attr,
    output logic               o_cell_damaged,
    output logic               o_any_damage
);

    logic [7:0]  r_grid_width;
    logic [6:0]  r_grid_height;
    logic [7:0]  r_tab_stop;
    logic [7:0]  r_draw_fg;
    logic [7:0]  r_draw_bg;
    logic [15:0] r_draw_attr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= 8'd80;
            r_grid_height <= 7'd25;
            r_tab_stop    <= 8'd8;
            r_draw_fg     <= 8'd7;
            r_draw_bg     <= 8'd0;
            r_draw_attr   <= 16'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_WIDTH:  r_grid_width  <= i_cfg_data[7:0];
                REG_HEIGHT: r_grid_height <= i_cfg_data[6:0];
                REG_TAB:    r_tab_stop    <= i_cfg_data[7:0];
                REG_FG:     r_draw_fg     <= i_cfg_data[7:0];
                REG_BG:     r_draw_bg     <= i_cfg_data[7:0];
                REG_ATTR:   r_draw_attr   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_cmd    cmd;
    t_status status;

    tcbw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_mode   (i_mode),
        .i_status (status),
        .busy     (busy),
        .o_cmd    (cmd)
    );

    tcbw_datapath #(
        .MAX_COLS    (MAX_COLS),
        .MAX_ROWS    (MAX_ROWS),
        .GLYPH_BYTES (GLYPH_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_grid_width   (r_grid_width),
        .i_grid_height  (r_grid_height),
        .i_tab_stop     (r_tab_stop),
        .i_draw_fg      (r_draw_fg),
        .i_draw_bg      (r_draw_bg),
        .i_draw_attr    (r_draw_attr),
        .i_mode         (i_mode),
        .i_char_code    (i_char_code),
        .i_char_len     (i_char_len),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_rect_w       (i_rect_w),
        .i_rect_h       (i_rect_h),
        .i_fill_fg      (i_fill_fg),
        .i_fill_bg      (i_fill_bg),
        .i_fill_attr    (i_fill_attr),
        .i_fill_mask    (i_fill_mask),
        .o_valid        (o_valid),
        .o_cursor_x     (o_cursor_x),
        .o_cursor_y     (o_cursor_y),
        .o_cell_char    (o_cell_char),
        .o_cell_len     (o_cell_len),
        .o_cell_fg      (o_cell_fg),
        .o_cell_bg      (o_cell_bg),
        .o_cell_attr    (o_cell_attr),
        .o_cell_damaged (o_cell_damaged),
        .o_any_damage   (o_any_damage)
    );

endmodule
